/* sv/dceq_pkg.sv */
package dceq_pkg;

  // Sequencer states of the event queue.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_DRAIN_RD,
    ST_DRAIN_CHK,
    ST_FINISH
  } dceq_state_e;

  // Result of the shared tick comparator.
  typedef struct packed {
    logic eq;
    logic le;
  } dceq_cmp_t;

  localparam int unsigned TICK_W      = 32;
  localparam int unsigned DELAY_W     = 16;
  localparam int unsigned ACTION_W    = 5;
  localparam int unsigned OUT_WORD_W  = 16;
  localparam int unsigned OUT_COUNT_W = 4;
  localparam int unsigned IN_DATA_W   = 72;
  localparam int unsigned OUT_DATA_W  = 40;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;

  localparam logic        MODE_PUSH  = 1'b0;
  localparam logic        MODE_DRAIN = 1'b1;

  localparam logic [APB_AW-1:0] ADDR_INPUT_DELAY = 3'h0;

endpackage

/* sv/dceq_cmp.sv */
// Shared 32-bit tick comparator: equality for pushes, less-or-equal for drains.
module dceq_cmp (
  input  logic [dceq_pkg::TICK_W-1:0] a_i,
  input  logic [dceq_pkg::TICK_W-1:0] b_i,
  output dceq_pkg::dceq_cmp_t         res_o
);

  assign res_o.eq = (a_i == b_i);
  assign res_o.le = (a_i <= b_i);

endmodule

/* sv/dceq_ring.sv */
// Ring storage: one write port and one registered read port.
module dceq_ring #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned IDX_W  = 4,
  parameter int unsigned DATA_W = 48
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [IDX_W-1:0]  waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [IDX_W-1:0]  raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* sv/delayed_control_event_queue.sv */
// Channel   | Direction | Contents
// ----------+-----------+---------------------------------------------------------
// s_axis    | in        | tuser: mode; tdata: bit number, level, event_tick, sim_tick
// m_axis    | out       | tdata: applied, pending, queue_count, dropped_oldest
// apb       | in/out    | register 0 at byte address 0: input_delay
//
// Push: the item is taken and its tick stamped, the ring is updated, then the result is
// loaded into the output register. Drain: each popped entry, and an entry not yet due at
// which it stops, is read from the ring and then checked, as the ring has one registered
// read port and each entry then goes through the shared comparator. No item is taken while
// one is in progress, and a stalled result holds the sequencer in its last state.
// Reset is asynchronous and clears the control state; the ring is read only where written.
module delayed_control_event_queue #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned CONTROL_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [4:0] control bit number, [5] level, [37:6] event_tick, [69:38] sim_tick, [71:70] zero
  input  logic [dceq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] mode
  input  logic                              s_axis_tuser,
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] applied_controls, [31:16] pending_controls, [35:32] queue_count,
  // [36] dropped_oldest, [39:37] zero
  output logic [dceq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dceq_pkg::APB_AW-1:0]       paddr,
  input  logic [dceq_pkg::APB_DW-1:0]       pwdata,
  output logic [dceq_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  localparam int unsigned IW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW     = IW + 1;
  localparam int unsigned SLOT_W = dceq_pkg::TICK_W + CONTROL_BITS;

  dceq_pkg::dceq_state_e state_q, state_d;

  logic                            mode_q;
  logic [dceq_pkg::ACTION_W-1:0]   action_q;
  logic                            level_q;
  logic [dceq_pkg::TICK_W-1:0]     tick_q;
  logic [dceq_pkg::DELAY_W-1:0]    delay_q;
  logic [IW-1:0]                   rd_q, rd_d;
  logic [IW-1:0]                   wr_q, wr_d;
  logic [IW-1:0]                   last_q, last_d;
  // Shadow copy of the last pushed entry, so a push needs no ring read.
  logic [dceq_pkg::TICK_W-1:0]     last_time_q, last_time_d;
  logic [CONTROL_BITS-1:0]         last_word_q, last_word_d;
  logic [CONTROL_BITS-1:0]         cur_word_q, cur_word_d;
  logic                            drop_q, drop_d;
  logic                            out_valid_q;
  logic [dceq_pkg::OUT_DATA_W-1:0] out_data_q;

  logic                            in_xfer;
  logic                            out_free;
  logic                            cfg_write;
  logic                            ring_we;
  logic [IW-1:0]                   ring_waddr;
  logic [SLOT_W-1:0]               ring_wdata;
  logic                            ring_re;
  logic [SLOT_W-1:0]               ring_rdata;
  logic [dceq_pkg::TICK_W-1:0]     slot_time;
  logic [CONTROL_BITS-1:0]         slot_word;
  logic [dceq_pkg::TICK_W-1:0]     cmp_a;
  logic [dceq_pkg::TICK_W-1:0]     cmp_b;
  dceq_pkg::dceq_cmp_t             cmp_res;
  logic [CONTROL_BITS-1:0]         bit_sel;
  logic [CONTROL_BITS-1:0]         new_word;
  logic [IW-1:0]                   wr_next;
  logic [IW-1:0]                   rd_next;
  logic [CW-1:0]                   count_full;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
    logic [IW-1:0] nxt;
    if (idx == IW'(QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + 1'b1;
    end
    return nxt;
  endfunction

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration port: single register, always ready.
  assign pready = 1'b1;
  assign prdata = (paddr == dceq_pkg::ADDR_INPUT_DELAY) ?
                  dceq_pkg::APB_DW'(delay_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
    end else if (cfg_write && (paddr == dceq_pkg::ADDR_INPUT_DELAY)) begin
      delay_q <= pwdata[dceq_pkg::DELAY_W-1:0];
    end
  end

  // Capture the item. For a push the stamped tick is formed here; for a drain the
  // simulated tick is kept in the same register.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q   <= s_axis_tuser;
      action_q <= s_axis_tdata[4:0];
      level_q  <= s_axis_tdata[5];
      if (s_axis_tuser == dceq_pkg::MODE_DRAIN) begin
        tick_q <= s_axis_tdata[69:38];
      end else begin
        tick_q <= s_axis_tdata[37:6] + dceq_pkg::TICK_W'(delay_q);
      end
    end
  end

  dceq_ring #(
    .DEPTH  (QUEUE_DEPTH),
    .IDX_W  (IW),
    .DATA_W (SLOT_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (rd_q),
    .rdata_o (ring_rdata)
  );

  assign slot_time = ring_rdata[SLOT_W-1:CONTROL_BITS];
  assign slot_word = ring_rdata[CONTROL_BITS-1:0];

  // The comparator serves both modes: the push checks the stamped tick against the
  // last entry's tick, the drain checks the head entry's tick against sim_tick.
  assign cmp_a = (state_q == dceq_pkg::ST_DRAIN_CHK) ? slot_time : tick_q;
  assign cmp_b = (state_q == dceq_pkg::ST_DRAIN_CHK) ? tick_q : last_time_q;

  dceq_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  // One-hot control bit; a bit number of zero or beyond the word selects nothing.
  always_comb begin
    for (int k = 0; k < int'(CONTROL_BITS); k++) begin
      bit_sel[k] = (int'(action_q) == k + 1);
    end
  end

  assign new_word = level_q ? (last_word_q | bit_sel) : (last_word_q & ~bit_sel);
  assign wr_next  = next_idx(wr_q);
  assign rd_next  = next_idx(rd_q);

  assign count_full = (wr_q >= rd_q) ? (CW'(wr_q) - CW'(rd_q)) :
                      (CW'(wr_q) + CW'(QUEUE_DEPTH) - CW'(rd_q));

  always_comb begin
    state_d     = state_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    last_d      = last_q;
    last_time_d = last_time_q;
    last_word_d = last_word_q;
    cur_word_d  = cur_word_q;
    drop_d      = drop_q;
    ring_we     = 1'b0;
    ring_waddr  = wr_q;
    ring_wdata  = {tick_q, new_word};
    ring_re     = 1'b0;

    case (state_q)
      dceq_pkg::ST_IDLE: begin
        if (in_xfer) begin
          drop_d  = 1'b0;
          state_d = (s_axis_tuser == dceq_pkg::MODE_DRAIN) ?
                    dceq_pkg::ST_DRAIN_RD : dceq_pkg::ST_PUSH;
        end
      end
      dceq_pkg::ST_PUSH: begin
        if (new_word != last_word_q) begin
          ring_we     = 1'b1;
          last_word_d = new_word;
          if (cmp_res.eq) begin
            // Same tick as the last entry: overwrite it in place.
            ring_waddr = last_q;
            ring_wdata = {last_time_q, new_word};
          end else begin
            last_d      = wr_q;
            last_time_d = tick_q;
            wr_d        = wr_next;
            if (wr_next == rd_q) begin
              rd_d   = rd_next;
              drop_d = 1'b1;
            end
          end
        end
        state_d = dceq_pkg::ST_FINISH;
      end
      dceq_pkg::ST_DRAIN_RD: begin
        if (rd_q != wr_q) begin
          ring_re = 1'b1;
          state_d = dceq_pkg::ST_DRAIN_CHK;
        end else begin
          state_d = dceq_pkg::ST_FINISH;
        end
      end
      dceq_pkg::ST_DRAIN_CHK: begin
        if (cmp_res.le) begin
          cur_word_d = slot_word;
          rd_d       = rd_next;
          state_d    = dceq_pkg::ST_DRAIN_RD;
        end else begin
          state_d = dceq_pkg::ST_FINISH;
        end
      end
      dceq_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = dceq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dceq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dceq_pkg::ST_IDLE;
      rd_q        <= '0;
      wr_q        <= '0;
      last_q      <= '0;
      last_time_q <= '0;
      last_word_q <= '0;
      cur_word_q  <= '0;
      drop_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      last_q      <= last_d;
      last_time_q <= last_time_d;
      last_word_q <= last_word_d;
      cur_word_q  <= cur_word_d;
      drop_q      <= drop_d;
    end
  end

  // Output register: loaded when the sequencer finishes and the slot is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == dceq_pkg::ST_FINISH) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == dceq_pkg::ST_FINISH) && out_free) begin
      out_data_q <= {3'b000,
                     drop_q && (mode_q == dceq_pkg::MODE_PUSH),
                     dceq_pkg::OUT_COUNT_W'(count_full),
                     dceq_pkg::OUT_WORD_W'(last_word_q),
                     dceq_pkg::OUT_WORD_W'(cur_word_q)};
    end
  end

  assign s_axis_tready = (state_q == dceq_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* sv/dceq_checker.sv */
// Port-level checks on the event queue.
module dceq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [dceq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  // A new result appears only at the end of an item's processing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result produced without an item in progress");

  // A discarded oldest entry means the ring is full afterwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[36]) |->
      (m_axis_tdata[35:32] == dceq_pkg::OUT_COUNT_W'(QUEUE_DEPTH - 1)))
    else $error("overflow reported with the ring not full");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind delayed_control_event_queue dceq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_dceq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
